[src/assoc_tag_store_lru_fifo_top_defines.svh]
// Assertion macros shared by the tag store top level.
`ifndef ASSOC_TAG_STORE_LRU_FIFO_TOP_DEFINES_SVH
`define ASSOC_TAG_STORE_LRU_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ATSLF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ATSLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/atslf_pkg.sv]
package atslf_pkg;

    localparam int ADDR_W  = 42;
    localparam int OCC_W   = 7;
    localparam int CAP_W   = 7;
    localparam int CFG_DW  = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Replacement policy codes.
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    // Register index codes, taken from paddr[2].
    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Sweep phase codes.
    localparam logic PH_SEARCH = 1'b0;
    localparam logic PH_UPDATE = 1'b1;

    typedef struct packed {
        logic sweep_start;
        logic sweep_phase;
        logic sweep_run;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic sweep_busy;
    } t_stat;

endpackage

[src/atslf_ctrl.sv]
module atslf_ctrl
    import atslf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SRCH = 4'b0010,
        S_UPD  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd.sweep_start = 1'b0;
        o_cmd.sweep_phase = PH_SEARCH;
        o_cmd.sweep_run   = 1'b0;
        o_cmd.finish      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.sweep_run = 1'b1;
                if (!i_stat.sweep_busy) begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.sweep_phase = PH_UPDATE;
                    n_state           = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.sweep_run = 1'b1;
                if (!i_stat.sweep_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/atslf_dp.sv]
module atslf_dp
    import atslf_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int TAG_BITS = 42
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ADDR_W-1:0] i_block_addr,
    input  logic              i_policy,
    input  logic [CAP_W-1:0]  i_capacity,
    output logic              o_valid,
    output logic              o_hit,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [TAG_BITS-1:0] mem_tag  [ENTRIES];
    logic [IW-1:0]       mem_rank [ENTRIES];

    logic [TAG_BITS-1:0] r_addr;
    logic [CW-1:0]       r_idx;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic                r_phase;
    logic [CW-1:0]       r_count;
    logic                r_hit;
    logic [IW-1:0]       r_hit_slot;
    logic [IW-1:0]       r_hit_rank;
    logic [IW-1:0]       r_vict_slot;
    logic [TAG_BITS-1:0] r_tag_q;
    logic [IW-1:0]       r_rank_q;
    logic                r_out_valid;
    logic                r_out_hit;
    logic [OCC_W-1:0]    r_out_occ;

    logic                issue;
    logic [EW-1:0]       cap_e;
    logic [EW-1:0]       cap_eff;
    logic                full;
    logic [IW-1:0]       target;
    logic [CW-1:0]       next_count;
    logic                rank_we;
    logic [IW-1:0]       rank_wa;
    logic [IW-1:0]       rank_wd;
    logic                tag_we;

    assign issue = i_cmd.sweep_run && (r_idx < r_count);
    assign o_stat.sweep_busy = (r_idx < r_count) || r_rd_vld;

    // Effective capacity is clamped to the range one to the entry count.
    always_comb begin
        cap_e = EW'(i_capacity);
        if (cap_e == '0) begin
            cap_eff = EW'(1);
        end else if (cap_e > EW'(ENTRIES)) begin
            cap_eff = EW'(ENTRIES);
        end else begin
            cap_eff = cap_e;
        end
    end

    assign full       = (EW'(r_count) >= cap_eff);
    assign target     = full ? r_vict_slot : r_count[IW-1:0];
    assign next_count = (r_hit || full) ? r_count : r_count + CW'(1);
    assign tag_we     = i_cmd.finish && !r_hit;

    always_comb begin
        rank_we = 1'b0;
        rank_wa = r_rd_idx;
        rank_wd = r_rank_q + IW'(1);
        if (i_cmd.finish) begin
            rank_we = !r_hit;
            rank_wa = target;
            rank_wd = '0;
        end else if (r_rd_vld && (r_phase == PH_UPDATE)) begin
            if (r_hit) begin
                if (i_policy == POLICY_LRU) begin
                    if (r_rd_idx == r_hit_slot) begin
                        rank_we = 1'b1;
                        rank_wd = '0;
                    end else if (r_rank_q < r_hit_rank) begin
                        rank_we = 1'b1;
                    end
                end
            end else if (!(full && (r_rd_idx == r_vict_slot))) begin
                rank_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            mem_tag[target] <= r_addr;
        end
        if (issue) begin
            r_tag_q <= mem_tag[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            mem_rank[rank_wa] <= rank_wd;
        end
        if (issue) begin
            r_rank_q <= mem_rank[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_phase     <= PH_SEARCH;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= issue;
            r_out_valid <= i_cmd.finish;
            if (i_cmd.sweep_start) begin
                r_idx   <= '0;
                r_phase <= i_cmd.sweep_phase;
                if (i_cmd.sweep_phase == PH_SEARCH) begin
                    r_hit <= 1'b0;
                end
            end else if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_rd_vld && (r_phase == PH_SEARCH) && !r_hit && (r_tag_q == r_addr)) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count <= next_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start && (i_cmd.sweep_phase == PH_SEARCH)) begin
            r_addr <= TAG_BITS'(i_block_addr);
        end
        if (issue) begin
            r_rd_idx <= r_idx[IW-1:0];
        end
        if (r_rd_vld && (r_phase == PH_SEARCH)) begin
            if (!r_hit && (r_tag_q == r_addr)) begin
                r_hit_slot <= r_rd_idx;
                r_hit_rank <= r_rank_q;
            end
            // The oldest valid entry holds the highest rank, occupancy minus one.
            if (r_rank_q == IW'(r_count - CW'(1))) begin
                r_vict_slot <= r_rd_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out_hit <= r_hit;
            r_out_occ <= OCC_W'(next_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_occupancy = r_out_occ;

endmodule

[src/assoc_tag_store_lru_fifo_top.sv]
// Fully associative tag store with least recently used or first in first out
// replacement. A request is accepted on a rising edge where start is high and
// busy is low; i_block_addr is sampled on that edge. The block then sweeps its
// valid entries twice through the tag and rank memories, once to find a hit and
// the victim and once to age the recency ranks, and on a miss finally writes the new tag.
// After both sweeps, o_valid pulses for one cycle, carrying o_hit and
// o_occupancy. The single read port of each memory limits each sweep to one
// entry per cycle. busy drops in the cycle the result is shown, so the next
// request can be taken in that same cycle. The receiver has no way to hold a
// result off: each result is valid for exactly that one cycle. Synchronous
// active-low reset empties the store, selects least recently used and sets
// the capacity to 64; no clearing pass is needed since the valid entries
// always occupy the lowest slots. The APB port holds the policy at byte
// address 0 and the capacity at byte address 4; the user must make writes only
// while the block is idle, and the block itself does not enforce this.
`include "assoc_tag_store_lru_fifo_top_defines.svh"

module assoc_tag_store_lru_fifo_top
    import atslf_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int TAG_BITS = 42
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               start,
    output logic               busy,
    input  logic [ADDR_W-1:0]  i_block_addr,
    // Result channel.
    output logic               o_valid,
    output logic               o_hit,
    output logic [OCC_W-1:0]   o_occupancy,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    logic             r_policy;
    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;
    logic             start_acc;
    t_cmd             cmd;
    t_stat            stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign start_acc = start && !busy;

    // The register index is taken from address bit two; the byte offset is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POLICY_LRU;
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_POLICY:   r_policy   <= pwdata[0];
                REG_CAPACITY: r_capacity <= pwdata[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POLICY:   prdata = {{(CFG_DW-1){1'b0}}, r_policy};
            REG_CAPACITY: prdata = {{(CFG_DW-CAP_W){1'b0}}, r_capacity};
            default:      prdata = '0;
        endcase
    end

    // The controller sequences the search sweep, the rank update sweep and the
    // final tag write; the datapath owns the memories and the occupancy count.
    atslf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    atslf_dp #(
        .ENTRIES  (ENTRIES),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_block_addr (i_block_addr),
        .i_policy     (r_policy),
        .i_capacity   (r_capacity),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_occupancy  (o_occupancy)
    );

    // An accepted request always makes the block busy on the next cycle.
    `ATSLF_ASSERT_NEXT(a_busy_after_start, start_acc, busy, "request accepted but block not busy")
    // A result is shown only while the controller is back in idle.
    `ATSLF_ASSERT_IMPL(a_result_when_idle, o_valid, !busy, "result strobe while block busy")
    // Every request produces a single one-cycle strobe.
    `ATSLF_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe held for two cycles")
    // A hit never changes the number of valid entries.
    `ATSLF_ASSERT_IMPL(a_hit_keeps_occ, o_valid && o_hit, o_occupancy == $past(o_occupancy), "occupancy changed on a hit")

endmodule
